/* hw/rtl/msb_pkg.sv */
`timescale 1ns / 1ps

package msb_pkg;

  // default sizes
  localparam int NUM_STACKS_DEF = 8;
  localparam int NUM_SLOTS_DEF  = 256;

  // field widths
  localparam int CMD_W  = 1;
  localparam int SID_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [CMD_W-1:0] OP_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] OP_POP  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // controller to datapath strobes
  typedef struct packed {
    logic accept;  // latch word, read stack-top store
    logic fetch;   // pick slot, read link and data stores
    logic commit;  // write back, load result register
  } ctrl_cmd_t;

endpackage

/* hw/rtl/msb_ctrl.sv */
`timescale 1ns / 1ps

module msb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output msb_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FETCH  = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  // result register free, or emptied this cycle
  assign load_ok    = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.fetch  = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (load_ok) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a word in flight blocks the input until its commit
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before commit");

  // an unread result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.commit)
    else $error("result register overwritten");

  // every commit presents a result next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");

endmodule

/* hw/rtl/msb_dpath.sv */
`timescale 1ns / 1ps

module msb_dpath #(
  parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEF,
  parameter int NUM_SLOTS  = msb_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  msb_pkg::ctrl_cmd_t          cmd,
  input  logic [msb_pkg::CMD_W-1:0]   in_command,
  input  logic [msb_pkg::SID_W-1:0]   in_stack_id,
  input  logic [msb_pkg::VAL_W-1:0]   in_value,
  output logic [msb_pkg::STAT_W-1:0]  out_status,
  output logic [msb_pkg::VAL_W-1:0]   out_popped_value
);

  localparam int PW = $clog2(NUM_SLOTS + 1);               // pointer, holds null
  localparam int AW = $clog2(NUM_SLOTS);                   // slot address
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int XW = (SW > msb_pkg::SID_W) ? SW : msb_pkg::SID_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);

  // stores
  logic [PW-1:0]            top_mem  [NUM_STACKS];
  logic [PW-1:0]            link_mem [NUM_SLOTS];
  logic [msb_pkg::VAL_W-1:0] data_mem [NUM_SLOTS];

  // control state
  logic [NUM_STACKS-1:0] top_vld_r, top_vld_nxt;
  logic [PW-1:0]         free_head_r, free_head_nxt;
  logic [PW-1:0]         fill_r, fill_nxt;  // link entries at or above this are untouched

  // per-word registers
  logic [msb_pkg::CMD_W-1:0]  op_r;
  logic [SW-1:0]              sid_addr_r;
  logic                       sid_ok_r;
  logic [msb_pkg::VAL_W-1:0]  val_r;
  logic [PW-1:0]              top_rd_r;
  logic                       top_hit_r;
  logic [PW-1:0]              slot_r;
  logic                       err_r;
  logic [PW-1:0]              link_rd_r;
  logic                       link_hit_r;
  logic [msb_pkg::VAL_W-1:0]  data_rd_r;
  logic [msb_pkg::STAT_W-1:0] out_status_r;
  logic [msb_pkg::VAL_W-1:0]  out_popped_r;

  logic [XW-1:0] in_sid_x;
  logic [SW-1:0] in_addr;
  logic          in_sid_ok;
  logic [PW-1:0] top_cur;
  logic [PW-1:0] slot_sel;
  logic [AW-1:0] slot_sel_a;
  logic [AW-1:0] slot_a;
  logic [PW-1:0] link_val;
  logic          is_push;
  logic          commit_ok;

  assign in_sid_x  = XW'(in_stack_id);
  assign in_addr   = in_sid_x[SW-1:0];
  assign in_sid_ok = (32'(in_stack_id) < 32'(NUM_STACKS));

  assign is_push    = (op_r == msb_pkg::OP_PUSH);
  assign top_cur    = top_hit_r ? top_rd_r : NULL_PTR;
  assign slot_sel   = is_push ? free_head_r : top_cur;
  assign slot_sel_a = slot_sel[AW-1:0];
  assign slot_a     = slot_r[AW-1:0];
  // untouched entries still hold the reset chain i -> i+1
  assign link_val   = link_hit_r ? link_rd_r : PW'(slot_r + PW'(1));
  assign commit_ok  = cmd.commit && !err_r;

  // word capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_command;
      sid_addr_r <= in_addr;
      sid_ok_r   <= in_sid_ok;
      val_r      <= in_value;
      top_hit_r  <= top_vld_r[in_addr];
    end
    if (cmd.fetch) begin
      slot_r     <= slot_sel;
      err_r      <= !sid_ok_r || (slot_sel >= NULL_PTR);
      link_hit_r <= (slot_sel < fill_r);
    end
  end

  // stack-top store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      top_rd_r <= top_mem[in_addr];
    end
    if (commit_ok) begin
      top_mem[sid_addr_r] <= is_push ? slot_r : link_val;
    end
  end

  // link store
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      link_rd_r <= link_mem[slot_sel_a];
    end
    if (commit_ok) begin
      link_mem[slot_a] <= is_push ? top_cur : free_head_r;
    end
  end

  // data store
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      data_rd_r <= data_mem[slot_sel_a];
    end
    if (commit_ok && is_push) begin
      data_mem[slot_a] <= val_r;
    end
  end

  always_comb begin
    top_vld_nxt   = top_vld_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    if (commit_ok) begin
      top_vld_nxt[sid_addr_r] = 1'b1;
      if (is_push) begin
        free_head_nxt = link_val;
        if (slot_r == fill_r) begin
          fill_nxt = PW'(fill_r + PW'(1));
        end
      end else begin
        free_head_nxt = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_vld_r   <= '0;
      free_head_r <= '0;
      fill_r      <= '0;
    end else begin
      top_vld_r   <= top_vld_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!err_r) begin
        out_status_r <= msb_pkg::ST_OK;
      end else if (is_push) begin
        out_status_r <= msb_pkg::ST_OVERFLOW;
      end else begin
        out_status_r <= msb_pkg::ST_UNDERFLOW;
      end
      out_popped_r <= (!err_r && !is_push) ? data_rd_r : '0;
    end
  end

  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NULL_PTR)
    else $error("fill count past store size");

  // a pop only ever returns a slot that was written
  a_pop_written: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_ok && !is_push) |-> (slot_r < fill_r))
    else $error("pop of unwritten slot");

  // a push takes a used slot or the first untouched one
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_ok && is_push) |-> (slot_r <= fill_r))
    else $error("push skipped untouched slots");

endmodule

/* hw/rtl/multi_stack_shared_buffer_top.sv */
`timescale 1ns / 1ps
// Channel | Ports                        | Word
// in      | in_tvalid/in_tready          | tdata: value[31:0]; tuser: command, stack_id
// out     | out_tvalid/out_tready        | tdata: popped_value[31:0]; tuser: status
//
// Each word goes through accept with stack-top read, slot pick with link/data
// read, then commit; the two registered store reads in series call for these steps.
// Reset: synchronous rst_n; all stacks empty, free list chained in slot order.
// A held result (out_tready low) parks the word in its commit cycle; the input
// takes a new word while a finished result waits to be taken.

module multi_stack_shared_buffer_top #(
  parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEF,
  parameter int NUM_SLOTS  = msb_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic [3:0]  in_tuser,    // [0] command, [3:1] stack_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] popped_value
  output logic [1:0]  out_tuser    // [1:0] status
);

  msb_pkg::ctrl_cmd_t cmd;

  msb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  msb_dpath #(
    .NUM_STACKS (NUM_STACKS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_command       (in_tuser[0]),
    .in_stack_id      (in_tuser[3:1]),
    .in_value         (in_tdata),
    .out_status       (out_tuser),
    .out_popped_value (out_tdata)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int NSTK    = msb_pkg::NUM_STACKS_DEF;
  localparam int NSLOT   = msb_pkg::NUM_SLOTS_DEF;
  localparam int PTR_W   = 9;
  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NSLOT);
  localparam int DRAIN_CYCLES = 12;   // extra wait for stray results after the drain
  localparam int LONG_HOLD    = 40;   // receiver hold-off, cycles

  // one result word: status in tuser, popped value in tdata
  typedef struct packed {
    logic [msb_pkg::STAT_W-1:0] status;
    logic [msb_pkg::VAL_W-1:0]  popped;
  } stack_result_t;

  // Predicts the shared-buffer stacks and holds the results still due.
  class StackScoreboard;
    logic [msb_pkg::VAL_W-1:0] slot_data [NSLOT];
    logic [PTR_W-1:0] slot_link [NSLOT];
    logic [PTR_W-1:0] stack_top [NSTK];
    logic [PTR_W-1:0] free_head;
    stack_result_t    due_results[$];
    int errors, checked, used;
    int push_ok, pop_ok, overflows, underflows;

    function new();
      foreach (slot_link[i]) slot_link[i] = PTR_W'(i + 1);
      slot_link[NSLOT-1] = PTR_NULL;
      foreach (slot_data[i]) slot_data[i] = '0;
      foreach (stack_top[i]) stack_top[i] = PTR_NULL;
      free_head = '0;
    endfunction

    // Apply one accepted word to the stacks and queue its result.
    function void note_word(logic [msb_pkg::CMD_W-1:0] cmd,
                            logic [msb_pkg::SID_W-1:0] sid,
                            logic [msb_pkg::VAL_W-1:0] val);
      stack_result_t r;
      logic [PTR_W-1:0] slot;
      r.status = msb_pkg::ST_OK;
      r.popped = '0;
      if (cmd == msb_pkg::OP_PUSH) begin
        slot = free_head;
        if (int'(sid) >= NSTK || slot >= PTR_NULL) begin
          r.status = msb_pkg::ST_OVERFLOW;
          overflows++;
        end else begin
          free_head       = slot_link[slot];
          slot_data[slot] = val;
          slot_link[slot] = stack_top[sid];
          stack_top[sid]  = slot;
          used++;
          push_ok++;
        end
      end else begin
        slot = (int'(sid) >= NSTK) ? PTR_NULL : stack_top[sid];
        if (slot >= PTR_NULL) begin
          r.status = msb_pkg::ST_UNDERFLOW;
          underflows++;
        end else begin
          stack_top[sid]  = slot_link[slot];
          slot_link[slot] = free_head;
          free_head       = slot;
          r.popped        = slot_data[slot];
          used--;
          pop_ok++;
        end
      end
      due_results.push_back(r);
    endfunction

    function void check_word(logic [msb_pkg::STAT_W-1:0] status,
                             logic [msb_pkg::VAL_W-1:0] popped);
      stack_result_t exp_r;
      checked++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result status %0d value %h", $time, status, popped);
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, exp_r.status, status);
        errors++;
      end
      if (popped !== exp_r.popped) begin
        $display("%0t: popped value mismatch: expected %h actual %h",
                 $time, exp_r.popped, popped);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;    // [31:0] value
  logic [3:0]        in_tuser = '0;    // [0] command, [3:1] stack_id
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;        // [31:0] popped_value
  logic [1:0]        out_tuser;        // [1:0] status

  StackScoreboard sb = new();

  // quiet: no idling on either side (final stretch of the run)
  bit quiet = 1'b0;
  // long_hold_req: asks the receiver for one long hold-off
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  multi_stack_shared_buffer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Offer one word, hold it until taken, then maybe leave a short gap.
  // tvalid stays high into the next word when there is no gap.
  task automatic send_word(input logic [msb_pkg::CMD_W-1:0] cmd,
                           input logic [msb_pkg::SID_W-1:0] sid,
                           input logic [msb_pkg::VAL_W-1:0] val);
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= {sid, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, sid, val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // One random word; push_pct sets the push/pop mix.
  task automatic send_random(input int push_pct);
    logic [msb_pkg::CMD_W-1:0] cmd;
    cmd = ($urandom_range(0, 99) < push_pct) ? msb_pkg::OP_PUSH : msb_pkg::OP_POP;
    send_word(cmd, msb_pkg::SID_W'($urandom_range(0, NSTK - 1)), $urandom);
  endtask

  // Sender stops until every result due has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: check on handshake, then choose tready for the next cycle.
  // Short random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_tvalid && out_tready) sb.check_word(out_tuser, out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-stack pops, extreme values, LIFO order, edge stack ids.
    send_word(msb_pkg::OP_POP,  3'd0, 32'hFFFF_FFFF);   // underflow on empty stack
    send_word(msb_pkg::OP_PUSH, 3'd0, 32'h0000_0000);
    send_word(msb_pkg::OP_PUSH, 3'd0, 32'h7FFF_FFFF);
    send_word(msb_pkg::OP_PUSH, 3'd7, 32'h8000_0000);
    send_word(msb_pkg::OP_PUSH, 3'd7, 32'hFFFF_FFFF);
    send_word(msb_pkg::OP_PUSH, 3'd3, 32'hAAAA_AAAA);
    send_word(msb_pkg::OP_PUSH, 3'd4, 32'h5555_5555);
    send_word(msb_pkg::OP_POP,  3'd0, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd0, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd0, 32'h0);           // underflow, stack already empty
    send_word(msb_pkg::OP_POP,  3'd7, 32'h1234_5678);
    send_word(msb_pkg::OP_PUSH, 3'd1, 32'h0000_0001);   // reuses freed slots
    send_word(msb_pkg::OP_PUSH, 3'd2, 32'hFFFF_FFFE);
    send_word(msb_pkg::OP_PUSH, 3'd5, 32'h8000_0001);
    send_word(msb_pkg::OP_PUSH, 3'd6, 32'h7FFF_FFFE);
    send_word(msb_pkg::OP_POP,  3'd7, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd7, 32'h0);           // underflow
    send_word(msb_pkg::OP_POP,  3'd3, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd4, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd6, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd5, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd2, 32'h0);
    send_word(msb_pkg::OP_POP,  3'd1, 32'h0);

    // sender pause: everything drains before the random part
    wait_drained();

    // Fill: push-heavy until the free list runs dry and overflows pile up.
    // Partway in, the receiver holds off so the block backs up its input.
    n = 0;
    while ((sb.overflows < 6 || n < 250) && n < 340) begin
      if (n == 40) long_hold_req = 1'b1;
      send_random(95);
      n++;
    end

    // Drain: pop-heavy until every stack is empty and underflows pile up.
    n = 0;
    while ((sb.used != 0 || n < 200) && n < 300) begin
      send_random(5);
      n++;
    end

    // Mixed traffic, no idling on either side.
    quiet = 1'b1;
    repeat (60) send_random(55);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.due_results.size());
      sb.errors++;
    end
    $display("covered: %0d good pushes, %0d good pops, %0d pushes to a full store,",
             sb.push_ok, sb.pop_ok, sb.overflows);
    $display("         %0d pops of empty stacks, %0d result words checked",
             sb.underflows, sb.checked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
